// ----- rtl/ttst_pkg.sv -----
// Shared types and constants of the tick timebase with soft timers.
`default_nettype none
package ttst_pkg;

    localparam int NUM_UP_DEFAULT   = 4;
    localparam int NUM_DOWN_DEFAULT = 4;
    localparam int CTR_IDX_W        = 4;

    localparam logic [5:0] TOKEN_MAX = 6'd63;

    localparam logic [4:0] OP_TICK       = 5'd0;
    localparam logic [4:0] OP_TOK_ADD    = 5'd1;
    localparam logic [4:0] OP_TOK_REMOVE = 5'd2;
    localparam logic [4:0] OP_TOK_CLEAR  = 5'd3;
    localparam logic [4:0] OP_UPDATE_ALL = 5'd4;
    localparam logic [4:0] OP_DOWN_FIRST = 5'd5;
    localparam logic [4:0] OP_DOWN_LAST  = 5'd12;
    localparam logic [4:0] OP_UP_FIRST   = 5'd13;
    localparam logic [4:0] OP_UP_LAST    = 5'd20;
    localparam logic [4:0] OP_WIN_RESET  = 5'd21;
    localparam logic [4:0] OP_WIN_START  = 5'd22;
    localparam logic [4:0] OP_WIN_READ   = 5'd23;

    localparam logic [2:0] CO_RESET      = 3'd0;
    localparam logic [2:0] CO_START      = 3'd1;
    localparam logic [2:0] CO_STOP       = 3'd2;
    localparam logic [2:0] CO_LOAD       = 3'd3;
    localparam logic [2:0] CO_LOAD_FORCE = 3'd4;
    localparam logic [2:0] CO_PERIOD     = 3'd5;
    localparam logic [2:0] CO_EXPIRY_EVT = 3'd6;
    localparam logic [2:0] CO_PERIOD_EVT = 3'd7;

    localparam logic [4:0] MOD_STEPS = 5'd16;
    localparam logic [4:0] MUL_STEPS = 5'd17;

    typedef struct packed {
        logic       op_en;
        logic       upd_en;
        logic       up_sel;
        logic [2:0] sub_op;
    } ctr_ctl_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  state;
        logic [31:0] value;
        logic [30:0] remain;
        logic        evt;
    } ctr_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ttst_iter.sv -----
// Iterative remainder and shift-add multiply unit.
`default_nettype none
module ttst_iter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        mul_mode,
    input  wire logic [31:0] a,
    input  wire logic [16:0] b,
    input  wire logic [31:0] c,
    output logic             done,
    output logic [31:0]      result
);

    localparam logic [4:0] MUL_LAST = ttst_pkg::MUL_STEPS - 5'd1;
    localparam logic [4:0] MOD_LAST = ttst_pkg::MOD_STEPS - 5'd1;

    logic        busy_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] a_reg;
    logic [16:0] b_reg;
    logic [31:0] acc_reg;
    logic [17:0] rem_reg;
    logic [17:0] rem_sh;
    logic [17:0] rem_next;
    logic        last;

    assign rem_sh   = {rem_reg[16:0], a_reg[15]};
    assign rem_next = (rem_sh >= {1'b0, b_reg}) ? rem_sh - {1'b0, b_reg} : rem_sh;
    assign last     = cnt_reg == (mode_reg ? MUL_LAST : MOD_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= mul_mode;
                cnt_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= c;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                a_reg   <= {a_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (mode_reg)
                begin
                    if (b_reg[0])
                        acc_reg <= acc_reg + a_reg;
                    b_reg <= {1'b0, b_reg[16:1]};
                end
                else
                begin
                    rem_reg <= rem_next;
                end
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = mode_reg ? acc_reg : {14'd0, rem_reg};

endmodule
`default_nettype wire

// ----- rtl/ttst_counters.sv -----
// Banks of second-resolution down and up counters.
`default_nettype none
module ttst_counters #(
    parameter int NUM_UP_COUNTERS   = ttst_pkg::NUM_UP_DEFAULT,
    parameter int NUM_DOWN_COUNTERS = ttst_pkg::NUM_DOWN_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ttst_pkg::ctr_ctl_t             ctl,
    input  wire logic [ttst_pkg::CTR_IDX_W-1:0] idx,
    input  wire logic [31:0]                    seconds,
    input  wire logic [31:0]                    operand,
    output ttst_pkg::ctr_stat_t                 stat
);

    localparam int UIW = (NUM_UP_COUNTERS > 1) ? $clog2(NUM_UP_COUNTERS) : 1;
    localparam int DIW = (NUM_DOWN_COUNTERS > 1) ? $clog2(NUM_DOWN_COUNTERS) : 1;

    localparam logic [1:0] ST_RESET = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_STOP  = 2'd2;
    localparam logic [1:0] ST_EXP   = 2'd3;

    logic [1:0]  d_state_reg  [NUM_DOWN_COUNTERS];
    logic [31:0] d_value_reg  [NUM_DOWN_COUNTERS];
    logic [31:0] d_end_reg    [NUM_DOWN_COUNTERS];
    logic [31:0] d_period_reg [NUM_DOWN_COUNTERS];
    logic        d_armed_reg  [NUM_DOWN_COUNTERS];
    logic [1:0]  u_state_reg  [NUM_UP_COUNTERS];
    logic [31:0] u_value_reg  [NUM_UP_COUNTERS];
    logic [31:0] u_end_reg    [NUM_UP_COUNTERS];
    logic [31:0] u_target_reg [NUM_UP_COUNTERS];
    logic [31:0] u_left_reg   [NUM_UP_COUNTERS];
    logic [31:0] u_period_reg [NUM_UP_COUNTERS];
    logic        u_armed_reg  [NUM_UP_COUNTERS];
    logic        evt_reg;

    logic           d_hit;
    logic           u_hit;
    logic [DIW-1:0] di;
    logic [UIW-1:0] ui;
    logic [31:0]    load_end;
    logic [31:0]    d_left;
    logic [31:0]    d_stop_end;
    logic [31:0]    d_pdiff;
    logic [31:0]    d_rem;
    logic [31:0]    u_left;
    logic [31:0]    u_run_val;
    logic [31:0]    u_stop_end;
    logic [31:0]    u_stop_val;
    logic [31:0]    u_per;
    logic [31:0]    u_rem;

    assign d_hit = int'(idx) < NUM_DOWN_COUNTERS;
    assign u_hit = int'(idx) < NUM_UP_COUNTERS;
    assign di    = DIW'(idx);
    assign ui    = UIW'(idx);

    assign load_end   = seconds + operand;
    assign d_left     = d_end_reg[di] - seconds;
    assign d_stop_end = d_value_reg[di] + seconds;
    assign d_pdiff    = d_value_reg[di] - operand;
    assign d_rem      = d_value_reg[di] - d_period_reg[di];
    assign u_left     = u_end_reg[ui] - seconds;
    assign u_run_val  = u_target_reg[ui] - u_left;
    assign u_stop_end = u_left_reg[ui] + seconds;
    assign u_stop_val = u_target_reg[ui] - u_left_reg[ui];
    assign u_per      = u_value_reg[ui] + operand;
    assign u_rem      = u_period_reg[ui] - u_value_reg[ui];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DOWN_COUNTERS; i++)
            begin
                d_state_reg[i]  <= ST_RESET;
                d_value_reg[i]  <= '0;
                d_end_reg[i]    <= '0;
                d_period_reg[i] <= '0;
                d_armed_reg[i]  <= 1'b0;
            end
            for (int i = 0; i < NUM_UP_COUNTERS; i++)
            begin
                u_state_reg[i]  <= ST_RESET;
                u_value_reg[i]  <= '0;
                u_end_reg[i]    <= '0;
                u_target_reg[i] <= '0;
                u_left_reg[i]   <= '0;
                u_period_reg[i] <= '0;
                u_armed_reg[i]  <= 1'b0;
            end
            evt_reg <= 1'b0;
        end
        else
        begin
            if (ctl.op_en)
                evt_reg <= 1'b0;
            if (ctl.op_en && !ctl.up_sel && d_hit)
            begin
                case (ctl.sub_op)
                    ttst_pkg::CO_RESET:
                    begin
                        d_state_reg[di] <= ST_RESET;
                        d_value_reg[di] <= '0;
                        d_end_reg[di]   <= '0;
                        d_armed_reg[di] <= 1'b0;
                    end
                    ttst_pkg::CO_START: d_state_reg[di] <= ST_RUN;
                    ttst_pkg::CO_STOP:  d_state_reg[di] <= ST_STOP;
                    ttst_pkg::CO_LOAD:
                    begin
                        if (d_state_reg[di] == ST_RESET)
                        begin
                            d_value_reg[di] <= operand;
                            d_end_reg[di]   <= load_end;
                            d_state_reg[di] <= ST_RUN;
                        end
                    end
                    ttst_pkg::CO_LOAD_FORCE:
                    begin
                        d_value_reg[di] <= operand;
                        d_end_reg[di]   <= load_end;
                        d_state_reg[di] <= ST_RUN;
                        d_armed_reg[di] <= 1'b0;
                    end
                    ttst_pkg::CO_PERIOD:
                    begin
                        if (!d_armed_reg[di])
                        begin
                            d_period_reg[di] <= d_pdiff[31] ? '0 : d_pdiff;
                            d_armed_reg[di]  <= 1'b1;
                        end
                    end
                    ttst_pkg::CO_EXPIRY_EVT:
                    begin
                        if (d_state_reg[di] == ST_EXP)
                        begin
                            d_state_reg[di] <= ST_RESET;
                            d_value_reg[di] <= '0;
                            d_end_reg[di]   <= '0;
                            d_armed_reg[di] <= 1'b0;
                            evt_reg         <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (d_armed_reg[di] && (d_rem[31] || d_rem == '0))
                        begin
                            d_armed_reg[di] <= 1'b0;
                            evt_reg         <= 1'b1;
                        end
                    end
                endcase
            end
            if (ctl.op_en && ctl.up_sel && u_hit)
            begin
                case (ctl.sub_op)
                    ttst_pkg::CO_RESET:
                    begin
                        u_state_reg[ui]  <= ST_RESET;
                        u_value_reg[ui]  <= '0;
                        u_end_reg[ui]    <= '0;
                        u_target_reg[ui] <= '0;
                        u_left_reg[ui]   <= '0;
                        u_period_reg[ui] <= '0;
                        u_armed_reg[ui]  <= 1'b0;
                    end
                    ttst_pkg::CO_START: u_state_reg[ui] <= ST_RUN;
                    ttst_pkg::CO_STOP:  u_state_reg[ui] <= ST_STOP;
                    ttst_pkg::CO_LOAD:
                    begin
                        if (u_state_reg[ui] == ST_RESET)
                        begin
                            u_value_reg[ui]  <= '0;
                            u_left_reg[ui]   <= '0;
                            u_target_reg[ui] <= operand;
                            u_end_reg[ui]    <= load_end;
                            u_state_reg[ui]  <= ST_RUN;
                        end
                    end
                    ttst_pkg::CO_LOAD_FORCE:
                    begin
                        u_value_reg[ui]  <= '0;
                        u_left_reg[ui]   <= '0;
                        u_target_reg[ui] <= operand;
                        u_end_reg[ui]    <= load_end;
                        u_state_reg[ui]  <= ST_RUN;
                        u_period_reg[ui] <= '0;
                        u_armed_reg[ui]  <= 1'b0;
                    end
                    ttst_pkg::CO_PERIOD:
                    begin
                        if (!u_armed_reg[ui])
                        begin
                            u_period_reg[ui] <= u_per;
                            u_armed_reg[ui]  <= 1'b1;
                        end
                    end
                    ttst_pkg::CO_EXPIRY_EVT:
                    begin
                        if (u_state_reg[ui] == ST_EXP)
                        begin
                            u_state_reg[ui]  <= ST_RESET;
                            u_value_reg[ui]  <= '0;
                            u_end_reg[ui]    <= '0;
                            u_target_reg[ui] <= '0;
                            u_left_reg[ui]   <= '0;
                            u_period_reg[ui] <= '0;
                            u_armed_reg[ui]  <= 1'b0;
                            evt_reg          <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (u_armed_reg[ui] && (u_rem[31] || u_rem == '0))
                        begin
                            u_armed_reg[ui] <= 1'b0;
                            evt_reg         <= 1'b1;
                        end
                    end
                endcase
            end
            if (ctl.upd_en && !ctl.up_sel && d_hit)
            begin
                if (d_state_reg[di] == ST_RUN)
                begin
                    if (d_left[31] || d_left == '0)
                    begin
                        d_state_reg[di] <= ST_EXP;
                        d_value_reg[di] <= '0;
                        d_end_reg[di]   <= '0;
                        d_armed_reg[di] <= 1'b0;
                    end
                    else
                    begin
                        d_value_reg[di] <= d_left;
                    end
                end
                else if (d_state_reg[di] == ST_STOP)
                begin
                    d_end_reg[di] <= d_stop_end;
                end
            end
            if (ctl.upd_en && ctl.up_sel && u_hit)
            begin
                if (u_state_reg[ui] == ST_RUN)
                begin
                    if (u_left[31] || u_left == '0)
                    begin
                        u_end_reg[ui]   <= '0;
                        u_left_reg[ui]  <= '0;
                        u_value_reg[ui] <= u_target_reg[ui];
                        u_state_reg[ui] <= ST_EXP;
                    end
                    else
                    begin
                        u_left_reg[ui]  <= u_left;
                        u_value_reg[ui] <= u_run_val;
                    end
                end
                else if (u_state_reg[ui] == ST_STOP)
                begin
                    u_end_reg[ui]   <= u_stop_end;
                    u_value_reg[ui] <= u_stop_val;
                end
            end
        end
    end

    always_comb
    begin
        stat     = '0;
        stat.evt = evt_reg;
        if (ctl.up_sel)
        begin
            stat.hit = u_hit;
            if (u_hit)
            begin
                stat.state  = u_state_reg[ui];
                stat.value  = u_value_reg[ui];
                stat.remain = u_rem[31] ? '0 : u_rem[30:0];
            end
        end
        else
        begin
            stat.hit = d_hit;
            if (d_hit)
            begin
                stat.state  = d_state_reg[di];
                stat.value  = d_value_reg[di];
                stat.remain = d_rem[31] ? '0 : d_rem[30:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tick_timebase_with_soft_timers.sv -----
// Top level: timebase, window timer, sequencer and output register.
//
// Command in: in_valid/in_ready beat carries operation, counter_index and
// operand_value. Result out: out_valid/out_ready beat with the timebase,
// addressed counter and window fields, one result per command.
// User writes update_rate via cfg_we/cfg_wdata only while idle; not enforced.
// One command at a time; in_ready is high only in the idle state.
// Steps from accept to out_valid:
//   tick: 16-step remainder in the iterative unit, then report,
//   update all: walk every up counter, then every down counter, then report,
//   other commands: execute, then report,
//   then, when the window timer runs, a 17-step shift-add
//   multiply in the same unit before the output register.
// The iterative unit computes tick remainders and running-window intervals.
// A finished result waits in the output register while the next command
// is taken; a new result waits for out_ready before it replaces it.
// Reset clears all counts, counters and the window; update_rate becomes 1.
`default_nettype none
module tick_timebase_with_soft_timers #(
    parameter int NUM_UP_COUNTERS   = ttst_pkg::NUM_UP_DEFAULT,
    parameter int NUM_DOWN_COUNTERS = ttst_pkg::NUM_DOWN_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [4:0]         operation,
    input  wire logic [1:0]         counter_index,
    input  wire logic signed [31:0] operand_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      seconds_now,
    output logic [15:0]             subseconds_now,
    output logic [5:0]              tokens_now,
    output logic [1:0]              counter_state,
    output logic signed [31:0]      counter_value,
    output logic [30:0]             period_remaining,
    output logic                    event_flag,
    output logic signed [31:0]      window_interval
);

    localparam int IW = ttst_pkg::CTR_IDX_W;
    localparam logic [IW-1:0] UP_LAST   = IW'(NUM_UP_COUNTERS - 1);
    localparam logic [IW-1:0] DOWN_LAST = IW'(NUM_DOWN_COUNTERS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_EXEC, S_WALK, S_REPORT, S_MUL, S_DONE
    } state_t;

    state_t      state_reg;
    logic [15:0] rate_reg;
    logic [31:0] sec_reg;
    logic [15:0] sub_reg;
    logic [5:0]  tok_reg;
    logic        win_run_reg;
    logic [31:0] win_sec_reg;
    logic [15:0] win_sub_reg;
    logic [4:0]  op_reg;
    logic [1:0]  idx_reg;
    logic [31:0] val_reg;
    logic        walk_up_reg;
    logic [IW-1:0] walk_reg;
    logic [1:0]  res_state_reg;
    logic [31:0] res_value_reg;
    logic [30:0] res_remain_reg;
    logic        res_evt_reg;
    logic [31:0] res_win_reg;
    logic        out_valid_reg;

    logic                 accept;
    logic                 is_ctr_op;
    logic                 is_up_op;
    logic [16:0]          rate_eff;
    logic [15:0]          sub_inc;
    logic                 it_start;
    logic                 it_mul;
    logic [31:0]          it_a;
    logic [31:0]          it_c;
    logic                 it_done;
    logic [31:0]          it_result;
    ttst_pkg::ctr_ctl_t   ctl;
    ttst_pkg::ctr_stat_t  stat;
    logic [IW-1:0]        ctr_idx;
    logic [4:0]           sub_base;

    assign accept    = in_valid && in_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign rate_eff  = (rate_reg == 16'd0) ? 17'h10000 : {1'b0, rate_reg};
    assign sub_inc   = sub_reg + 16'd1;
    assign is_up_op  = op_reg >= ttst_pkg::OP_UP_FIRST && op_reg <= ttst_pkg::OP_UP_LAST;
    assign is_ctr_op = is_up_op ||
        (op_reg >= ttst_pkg::OP_DOWN_FIRST && op_reg <= ttst_pkg::OP_DOWN_LAST);
    assign sub_base  = is_up_op ? ttst_pkg::OP_UP_FIRST : ttst_pkg::OP_DOWN_FIRST;

    assign it_start = (accept && operation == ttst_pkg::OP_TICK) ||
                      (state_reg == S_REPORT && win_run_reg);
    assign it_mul   = state_reg != S_IDLE;
    assign it_a     = it_mul ? sec_reg - win_sec_reg : {16'd0, sub_inc};
    assign it_c     = {16'd0, sub_reg} - {16'd0, win_sub_reg};

    assign ctr_idx    = (state_reg == S_WALK) ? walk_reg : IW'(idx_reg);
    assign ctl.op_en  = state_reg == S_EXEC && is_ctr_op;
    assign ctl.upd_en = state_reg == S_WALK;
    assign ctl.up_sel = (state_reg == S_WALK) ? walk_up_reg : is_up_op;
    assign ctl.sub_op = 3'(op_reg - sub_base);

    ttst_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (it_start),
        .mul_mode (it_mul),
        .a        (it_a),
        .b        (rate_eff),
        .c        (it_c),
        .done     (it_done),
        .result   (it_result)
    );

    ttst_counters #(
        .NUM_UP_COUNTERS   (NUM_UP_COUNTERS),
        .NUM_DOWN_COUNTERS (NUM_DOWN_COUNTERS)
    ) u_counters (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .idx     (ctr_idx),
        .seconds (sec_reg),
        .operand (val_reg),
        .stat    (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= 16'd1;
            sec_reg       <= '0;
            sub_reg       <= '0;
            tok_reg       <= '0;
            win_run_reg   <= 1'b0;
            win_sec_reg   <= '0;
            win_sub_reg   <= '0;
            walk_up_reg   <= 1'b1;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rate_reg <= cfg_wdata;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= operation;
                        idx_reg     <= counter_index;
                        val_reg     <= operand_value;
                        walk_up_reg <= 1'b1;
                        walk_reg    <= '0;
                        if (operation == ttst_pkg::OP_TICK)
                        begin
                            sub_reg   <= sub_inc;
                            state_reg <= S_MOD;
                        end
                        else if (operation == ttst_pkg::OP_UPDATE_ALL)
                            state_reg <= S_WALK;
                        else
                            state_reg <= S_EXEC;
                    end
                end
                S_MOD:
                begin
                    if (it_done)
                    begin
                        if (it_result == '0)
                        begin
                            sec_reg <= sec_reg + 32'd1;
                            if (tok_reg == '0)
                                sub_reg <= '0;
                        end
                        state_reg <= S_REPORT;
                    end
                end
                S_WALK:
                begin
                    if (walk_up_reg)
                    begin
                        if (walk_reg == UP_LAST)
                        begin
                            walk_up_reg <= 1'b0;
                            walk_reg    <= '0;
                        end
                        else
                            walk_reg <= walk_reg + IW'(1);
                    end
                    else
                    begin
                        if (walk_reg == DOWN_LAST)
                            state_reg <= S_REPORT;
                        else
                            walk_reg <= walk_reg + IW'(1);
                    end
                end
                S_EXEC:
                begin
                    case (op_reg) inside
                        ttst_pkg::OP_TOK_ADD:
                            if (tok_reg < ttst_pkg::TOKEN_MAX)
                                tok_reg <= tok_reg + 6'd1;
                        ttst_pkg::OP_TOK_REMOVE:
                            if (tok_reg != '0)
                                tok_reg <= tok_reg - 6'd1;
                        ttst_pkg::OP_TOK_CLEAR:
                            tok_reg <= '0;
                        ttst_pkg::OP_WIN_RESET:
                        begin
                            win_run_reg <= 1'b0;
                            win_sec_reg <= '0;
                            win_sub_reg <= '0;
                        end
                        ttst_pkg::OP_WIN_START:
                            if (!win_run_reg)
                            begin
                                win_sec_reg <= sec_reg;
                                win_sub_reg <= sub_reg;
                                win_run_reg <= 1'b1;
                            end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    res_state_reg  <= '0;
                    res_value_reg  <= '0;
                    res_remain_reg <= '0;
                    res_evt_reg    <= 1'b0;
                    res_win_reg    <= '0;
                    if (is_ctr_op && stat.hit)
                    begin
                        res_state_reg  <= stat.state;
                        res_value_reg  <= stat.value;
                        res_remain_reg <= stat.remain;
                        res_evt_reg    <= stat.evt;
                    end
                    state_reg <= win_run_reg ? S_MUL : S_DONE;
                end
                S_MUL:
                begin
                    if (it_done)
                    begin
                        res_win_reg <= it_result;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        seconds_now      <= sec_reg;
                        subseconds_now   <= sub_reg;
                        tokens_now       <= tok_reg;
                        counter_state    <= res_state_reg;
                        counter_value    <= res_value_reg;
                        period_remaining <= res_remain_reg;
                        event_flag       <= res_evt_reg;
                        window_interval  <= res_win_reg;
                        out_valid_reg    <= 1'b1;
                        if (op_reg == ttst_pkg::OP_WIN_READ)
                        begin
                            win_run_reg <= 1'b0;
                            win_sec_reg <= '0;
                            win_sub_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the tick timebase: command beats checked against a behavioral predictor.
`timescale 1ns / 1ps
module tb;

    typedef struct {
        logic [4:0]  op;
        logic [1:0]  idx;
        logic [31:0] val;
        logic        is_cfg;
        logic [15:0] rate;
    } cmd_t;

    typedef struct {
        logic [31:0] sec;
        logic [15:0] sub;
        logic [5:0]  tok;
        logic [1:0]  st;
        logic [31:0] cval;
        logic [30:0] rem;
        logic        ev;
        logic [31:0] win;
    } res_t;

    localparam logic [1:0] S_RESET = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_STOP  = 2'd2;
    localparam logic [1:0] S_EXP   = 2'd3;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic in_valid = 1'b0;
    logic [4:0] operation = 5'd0;
    logic [1:0] counter_index = 2'd0;
    logic signed [31:0] operand_value = 32'sd0;
    logic out_ready = 1'b0;
    logic in_taken = 1'b0;
    wire in_ready, out_valid, event_flag;
    wire signed [31:0] seconds_now, counter_value, window_interval;
    wire [15:0] subseconds_now;
    wire [5:0] tokens_now;
    wire [1:0] counter_state;
    wire [30:0] period_remaining;

    tick_timebase_with_soft_timers dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .counter_index(counter_index), .operand_value(operand_value),
        .out_valid(out_valid), .out_ready(out_ready), .seconds_now(seconds_now),
        .subseconds_now(subseconds_now), .tokens_now(tokens_now),
        .counter_state(counter_state), .counter_value(counter_value),
        .period_remaining(period_remaining), .event_flag(event_flag),
        .window_interval(window_interval)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [15:0] rate;
    logic [31:0] secs;
    logic [15:0] subs;
    logic [5:0]  toks;
    logic        win_on;
    logic [31:0] win_sec;
    logic [15:0] win_sub;
    logic [1:0]  dn_st [4];
    logic [31:0] dn_val [4], dn_end [4], dn_per [4];
    logic        dn_arm [4];
    logic [1:0]  up_st [4];
    logic [31:0] up_val [4], up_end [4], up_tgt [4], up_left [4], up_per [4];
    logic        up_arm [4];

    cmd_t pending[$];
    res_t expected_results[$];
    int sender_idle_pct, receiver_idle_pct;
    int hold_cycles;
    int errors, mismatches;
    int quiet_cycles;

    function automatic logic [31:0] clamp_pos(logic [31:0] v);
        return v[31] ? 32'd0 : v;
    endfunction

    function automatic logic [31:0] window_now();
        logic [32:0] r;
        r = (rate == 16'd0) ? 33'h10000 : {17'd0, rate};
        if (!win_on)
            return 32'd0;
        return (secs - win_sec) * r[31:0] + ({16'd0, subs} - {16'd0, win_sub});
    endfunction

    function automatic void clear_down(int i);
        dn_end[i] = 0; dn_val[i] = 0; dn_st[i] = S_RESET; dn_arm[i] = 1'b0;
    endfunction

    function automatic void clear_up(int i);
        up_st[i] = S_RESET; up_val[i] = 0; up_end[i] = 0; up_tgt[i] = 0;
        up_left[i] = 0; up_per[i] = 0; up_arm[i] = 1'b0;
    endfunction

    task automatic model_init();
        rate = 16'd1; secs = 0; subs = 0; toks = 0;
        win_on = 1'b0; win_sec = 0; win_sub = 0;
        for (int i = 0; i < 4; i++)
        begin
            clear_down(i); dn_per[i] = 0; clear_up(i);
        end
    endtask

    function automatic void update_counters();
        for (int i = 0; i < 4; i++)
        begin
            if (up_st[i] == S_RUN)
            begin
                up_left[i] = up_end[i] - secs;
                up_val[i] = up_tgt[i] - up_left[i];
                if (up_left[i] == 0 || up_left[i][31])
                begin
                    up_end[i] = 0; up_left[i] = 0; up_val[i] = up_tgt[i]; up_st[i] = S_EXP;
                end
            end
            else if (up_st[i] == S_STOP)
            begin
                up_end[i] = up_left[i] + secs;
                up_val[i] = up_tgt[i] - up_left[i];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (dn_st[i] == S_RUN)
            begin
                dn_val[i] = dn_end[i] - secs;
                if (dn_val[i] == 0 || dn_val[i][31])
                begin
                    clear_down(i); dn_st[i] = S_EXP;
                end
            end
            else if (dn_st[i] == S_STOP)
                dn_end[i] = dn_val[i] + secs;
        end
    endfunction

    function automatic res_t predict_result(cmd_t c);
        res_t r;
        int i;
        logic [2:0] sop;
        logic [32:0] m;
        logic win_fixed;
        r = '{default: '0};
        i = c.idx;
        win_fixed = 1'b0;
        m = (rate == 16'd0) ? 33'h10000 : {17'd0, rate};
        if (c.op == ttst_pkg::OP_TICK)
        begin
            subs = subs + 16'd1;
            if (({16'd0, subs} % m[31:0]) == 0)
            begin
                secs = secs + 1;
                if (toks == 0)
                    subs = 0;
            end
        end
        else if (c.op == ttst_pkg::OP_TOK_ADD)
        begin
            if (toks < ttst_pkg::TOKEN_MAX)
                toks = toks + 1;
        end
        else if (c.op == ttst_pkg::OP_TOK_REMOVE)
        begin
            if (toks > 0)
                toks = toks - 1;
        end
        else if (c.op == ttst_pkg::OP_TOK_CLEAR)
            toks = 0;
        else if (c.op == ttst_pkg::OP_UPDATE_ALL)
            update_counters();
        else if (c.op >= ttst_pkg::OP_DOWN_FIRST && c.op <= ttst_pkg::OP_DOWN_LAST)
        begin
            sop = 3'(c.op - ttst_pkg::OP_DOWN_FIRST);
            case (sop)
                ttst_pkg::CO_RESET: clear_down(i);
                ttst_pkg::CO_START: dn_st[i] = S_RUN;
                ttst_pkg::CO_STOP: dn_st[i] = S_STOP;
                ttst_pkg::CO_LOAD, ttst_pkg::CO_LOAD_FORCE:
                begin
                    if (sop == ttst_pkg::CO_LOAD_FORCE)
                        clear_down(i);
                    if (dn_st[i] == S_RESET)
                    begin
                        dn_val[i] = c.val; dn_end[i] = secs + c.val; dn_st[i] = S_RUN;
                    end
                end
                ttst_pkg::CO_PERIOD:
                    if (!dn_arm[i])
                    begin
                        dn_per[i] = clamp_pos(dn_val[i] - c.val); dn_arm[i] = 1'b1;
                    end
                ttst_pkg::CO_EXPIRY_EVT:
                    if (dn_st[i] == S_EXP)
                    begin
                        clear_down(i); r.ev = 1'b1;
                    end
                default:
                    if (dn_arm[i] && clamp_pos(dn_val[i] - dn_per[i]) == 0)
                    begin
                        dn_arm[i] = 1'b0; r.ev = 1'b1;
                    end
            endcase
            r.st = dn_st[i]; r.cval = dn_val[i];
            r.rem = 31'(clamp_pos(dn_val[i] - dn_per[i]));
        end
        else if (c.op >= ttst_pkg::OP_UP_FIRST && c.op <= ttst_pkg::OP_UP_LAST)
        begin
            sop = 3'(c.op - ttst_pkg::OP_UP_FIRST);
            case (sop)
                ttst_pkg::CO_RESET: clear_up(i);
                ttst_pkg::CO_START: up_st[i] = S_RUN;
                ttst_pkg::CO_STOP: up_st[i] = S_STOP;
                ttst_pkg::CO_LOAD, ttst_pkg::CO_LOAD_FORCE:
                begin
                    if (sop == ttst_pkg::CO_LOAD_FORCE)
                        clear_up(i);
                    if (up_st[i] == S_RESET)
                    begin
                        up_val[i] = 0; up_left[i] = 0; up_tgt[i] = c.val;
                        up_end[i] = secs + c.val; up_st[i] = S_RUN;
                    end
                end
                ttst_pkg::CO_PERIOD:
                    if (!up_arm[i])
                    begin
                        up_per[i] = up_val[i] + c.val; up_arm[i] = 1'b1;
                    end
                ttst_pkg::CO_EXPIRY_EVT:
                    if (up_st[i] == S_EXP)
                    begin
                        clear_up(i); r.ev = 1'b1;
                    end
                default:
                    if (up_arm[i] && clamp_pos(up_per[i] - up_val[i]) == 0)
                    begin
                        up_arm[i] = 1'b0; r.ev = 1'b1;
                    end
            endcase
            r.st = up_st[i]; r.cval = up_val[i];
            r.rem = 31'(clamp_pos(up_per[i] - up_val[i]));
        end
        else if (c.op == ttst_pkg::OP_WIN_RESET)
        begin
            win_on = 1'b0; win_sec = 0; win_sub = 0;
        end
        else if (c.op == ttst_pkg::OP_WIN_START)
        begin
            if (!win_on)
            begin
                win_sec = secs; win_sub = subs; win_on = 1'b1;
            end
        end
        else if (c.op == ttst_pkg::OP_WIN_READ)
        begin
            r.win = window_now();
            win_fixed = 1'b1;
            win_on = 1'b0; win_sec = 0; win_sub = 0;
        end
        if (!win_fixed)
            r.win = window_now();
        r.sec = secs; r.sub = subs; r.tok = toks;
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        cmd_t c;
        logic we;
        if (rst_n)
        begin
            we = 1'b0;
            if (!in_valid || in_taken)
            begin
                if (pending.size() != 0 && pending[0].is_cfg)
                begin
                    in_valid <= 1'b0;
                    if (!in_valid && expected_results.size() == 0 && in_ready)
                    begin
                        c = pending.pop_front();
                        we = 1'b1;
                        cfg_wdata <= c.rate;
                    end
                end
                else if (pending.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    c = pending.pop_front();
                    in_valid <= 1'b1;
                    operation <= c.op;
                    counter_index <= c.idx;
                    operand_value <= c.val;
                end
                else
                    in_valid <= 1'b0;
            end
            cfg_we <= we;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // monitor: predicts on accepted commands, checks accepted results
    always @(posedge clk)
    begin
        res_t e;
        cmd_t c;
        logic beat;
        if (rst_n)
        begin
            beat = 1'b0;
            in_taken = in_valid && in_ready;
            if (cfg_we)
                rate = cfg_wdata;
            if (in_taken)
            begin
                c.op = operation; c.idx = counter_index; c.val = operand_value;
                expected_results.push_back(predict_result(c));
                beat = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                beat = 1'b1;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("unexpected result beat at %0t", $realtime);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.sec !== seconds_now || e.sub !== subseconds_now ||
                        e.tok !== tokens_now || e.st !== counter_state ||
                        e.cval !== counter_value || e.rem !== period_remaining ||
                        e.ev !== event_flag || e.win !== window_interval)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("beat mismatch exp: sec %h sub %h tok %h st %h %s",
                                e.sec, e.sub, e.tok, e.st, "");
                            $display("  val %h rem %h ev %b win %h",
                                e.cval, e.rem, e.ev, e.win);
                            $display("beat mismatch got: sec %h sub %h tok %h st %h %s",
                                seconds_now, subseconds_now, tokens_now, counter_state, "");
                            $display("  val %h rem %h ev %b win %h",
                                counter_value, period_remaining, event_flag,
                                window_interval);
                        end
                    end
                end
            end
            quiet_cycles <= beat ? 0 : quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && quiet_cycles >= STALL_LIMIT)
        begin
            $display("tick_timebase_with_soft_timers: mismatch");
            $finish;
        end
    end

    task automatic add_cmd(logic [4:0] op, logic [1:0] idx, logic [31:0] val);
        cmd_t c;
        c.op = op; c.idx = idx; c.val = val; c.is_cfg = 1'b0; c.rate = 0;
        pending.push_back(c);
    endtask

    task automatic add_rate(logic [15:0] r);
        cmd_t c;
        c.op = 0; c.idx = 0; c.val = 0; c.is_cfg = 1'b1; c.rate = r;
        pending.push_back(c);
    endtask

    function automatic logic [31:0] rand_seconds();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7FFFFFFF - $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            default: return $urandom_range(6);
        endcase
    endfunction

    // well-formed counter life cycles with random content, plus noise
    task automatic add_random(int n);
        int k;
        logic [1:0] ix;
        logic base;
        logic [4:0] first;
        k = 0;
        while (k < n)
        begin
            ix = 2'($urandom_range(3));
            base = $urandom_range(1);
            first = base ? ttst_pkg::OP_UP_FIRST : ttst_pkg::OP_DOWN_FIRST;
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    add_cmd(first + ttst_pkg::CO_LOAD_FORCE, ix, $urandom_range(5));
                    add_cmd(first + ttst_pkg::CO_PERIOD, ix, $urandom_range(3));
                    add_cmd(ttst_pkg::OP_TICK, 0, 0);
                    add_cmd(ttst_pkg::OP_UPDATE_ALL, 0, 0);
                    add_cmd(first + ttst_pkg::CO_PERIOD_EVT, ix, 0);
                    add_cmd(first + ttst_pkg::CO_EXPIRY_EVT, ix, 0);
                    k += 6;
                end
                3, 4:
                begin
                    repeat ($urandom_range(4))
                    begin
                        add_cmd(ttst_pkg::OP_TICK, 0, 0);
                        k++;
                    end
                    add_cmd(ttst_pkg::OP_UPDATE_ALL, 0, 0);
                    k++;
                end
                5:
                begin
                    add_cmd(ttst_pkg::OP_WIN_START, 0, 0);
                    add_cmd(ttst_pkg::OP_TICK, 0, 0);
                    add_cmd($urandom_range(1) ? ttst_pkg::OP_WIN_READ : ttst_pkg::OP_WIN_RESET,
                        0, 0);
                    k += 3;
                end
                6:
                begin
                    add_cmd(5'($urandom_range(ttst_pkg::OP_TOK_ADD, ttst_pkg::OP_TOK_CLEAR)),
                        0, 0);
                    k++;
                end
                default:
                begin
                    add_cmd(5'($urandom_range(31)), 2'($urandom_range(3)), rand_seconds());
                    k++;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        errors = 0; mismatches = 0; quiet_cycles = 0; hold_cycles = 0;
        sender_idle_pct = 17; receiver_idle_pct = 82;
        model_init();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every operation, zero rate, overflow, saturation
        add_rate(16'd2);
        for (int op = 0; op < 32; op++)
            add_cmd(5'(op), 2'(op), op[0] ? 32'h7FFFFFFF : 32'h80000000);
        add_cmd(ttst_pkg::OP_DOWN_FIRST + ttst_pkg::CO_LOAD_FORCE, 2'd3, 32'hFFFFFFFF);
        add_cmd(ttst_pkg::OP_UP_FIRST + ttst_pkg::CO_LOAD_FORCE, 2'd0, 32'h00000001);
        add_cmd(ttst_pkg::OP_TICK, 0, 0);
        add_cmd(ttst_pkg::OP_TICK, 0, 0);
        add_cmd(ttst_pkg::OP_UPDATE_ALL, 0, 0);
        add_cmd(ttst_pkg::OP_UP_FIRST + ttst_pkg::CO_EXPIRY_EVT, 2'd0, 0);
        add_cmd(ttst_pkg::OP_DOWN_FIRST + ttst_pkg::CO_EXPIRY_EVT, 2'd3, 0);
        repeat (64) add_cmd(ttst_pkg::OP_TOK_ADD, 0, 0);
        repeat (65) add_cmd(ttst_pkg::OP_TOK_REMOVE, 0, 0);
        wait_drained();

        add_rate(16'd0);
        add_cmd(ttst_pkg::OP_WIN_START, 0, 0);
        add_random(200);
        add_cmd(ttst_pkg::OP_WIN_READ, 0, 0);
        wait_drained();

        add_rate(16'hFFFF);
        add_random(200);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_cycles = 400;
        add_random(30);
        wait_drained();

        sender_idle_pct = 82; receiver_idle_pct = 17;
        add_rate(16'd1);
        add_random(400);
        wait_drained();

        sender_idle_pct = 0; receiver_idle_pct = 0;
        add_rate(16'($urandom_range(1, 5)));
        add_random(450);
        wait_drained();

        if (errors == 0)
            $display("tick_timebase_with_soft_timers: match");
        else
            $display("tick_timebase_with_soft_timers: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ttst_pkg.sv
rtl/ttst_iter.sv
rtl/ttst_counters.sv
rtl/tick_timebase_with_soft_timers.sv
verif/tb.sv
